// ===== rtl/core/ddk_pkg.sv =====
// ----------------------------------------------------------------------------
// Distance decay kernel row: shared package
// Field widths, register codes, opcodes and the e^-1 constant of the
// exponential unit.
// ----------------------------------------------------------------------------
package ddk_pkg;

  localparam int MAX_PATCHES_DEF  = 64;
  localparam int COORD_BITS       = 10;
  localparam int COORD_W          = 2 * COORD_BITS;
  localparam int WEIGHT_FRAC_BITS = 16;
  localparam int WEIGHT_W         = WEIGHT_FRAC_BITS + 1;
  localparam int POT_W            = 16;
  localparam int IDX_IN_W         = 6;
  localparam int DECAY_W          = 16;
  localparam int PCOUNT_W         = 7;
  localparam int CFG_IDX_W        = 4;
  localparam int CFG_DATA_W       = 16;
  localparam int EXP_N_MAX        = 40;
  localparam int TAYLOR_TERMS     = 16;

  localparam logic [DECAY_W-1:0]  DECAY_RESET  = 16'd4096;
  localparam logic [PCOUNT_W-1:0] PCOUNT_RESET = 7'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DECAY  = 4'd0,
    CFG_PCOUNT = 4'd1
  } cfg_reg_t;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_ROW  = 1'b1
  } opcode_t;

  // e^-1 in Q0.32: the truncated alternating series at f = 1.0, where each
  // term is the previous one divided by k, even and odd sums kept apart
  localparam logic [31:0] EXP_NEG_ONE_Q32 = 32'd1580030169;

endpackage

// ===== rtl/core/ddk_ifs.sv =====
// ----------------------------------------------------------------------------
// Distance decay kernel row: channel interfaces
// Valid/ready channels for request items, result items and register writes.
// ----------------------------------------------------------------------------
interface ddk_in_if
  import ddk_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic                  opcode;
  logic [IDX_IN_W-1:0]   patch_index;
  logic [COORD_BITS-1:0] coord_x;
  logic [COORD_BITS-1:0] coord_y;
  modport source (output valid, opcode, patch_index, coord_x, coord_y, input ready);
  modport sink   (input valid, opcode, patch_index, coord_x, coord_y, output ready);
endinterface

interface ddk_out_if
  import ddk_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [IDX_IN_W-1:0] column_index;
  logic [WEIGHT_W-1:0] weight;
  logic                degenerate;
  logic                last;
  modport source (output valid, column_index, weight, degenerate, last, input ready);
  modport sink   (input valid, column_index, weight, degenerate, last, output ready);
endinterface

interface ddk_cfg_if
  import ddk_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/distance_decay_kernel_row_top.sv =====
// ----------------------------------------------------------------------------
// Distance decay kernel row: top level
// Coordinate store, potential buffer, row sequencer and normalizer.
// ----------------------------------------------------------------------------
//  channel | dir | handshake     | payload
//  in_ch   | in  | valid/ready   | opcode, patch_index, coord_x, coord_y
//  out_ch  | out | valid/ready   | column_index, weight, degenerate, last
//  cfg_ch  | in  | valid/ready   | index, data (ready always high)
//
//  A load item writes the coordinate store. A row item first runs each
//  off-diagonal column through the potential unit: the digit-serial square
//  root, 16 series terms in the divide-by-k unit and one e^-1 multiply per
//  whole unit of decay*dist (up to 40); then each column passes the
//  normalizing divider. A column whose exponent passes 40 skips the series
//  and the multiplies.
//  Reset (rst_n low, synchronous) clears control; both stores stay unwritten.
//  Input is taken only between rows; results wait in one output register.
// ----------------------------------------------------------------------------
module distance_decay_kernel_row_top
  import ddk_pkg::*;
#(
  parameter int MAX_PATCHES = MAX_PATCHES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  ddk_in_if.sink    in_ch,
  ddk_out_if.source out_ch,
  ddk_cfg_if.sink   cfg_ch
);
  localparam int IDX_W = $clog2(MAX_PATCHES);
  localparam int CMP_W = (IDX_W > IDX_IN_W) ? IDX_W : IDX_IN_W;
  localparam int SUM_W = POT_W + IDX_W;
  localparam int NUM_W = (((POT_W + WEIGHT_FRAC_BITS) > (SUM_W - 1)) ?
                          (POT_W + WEIGHT_FRAC_BITS) : (SUM_W - 1)) + 1;

  typedef enum logic [8:0] {
    ST_IDLE    = 9'b000000001,
    ST_SELF    = 9'b000000010,  // row patch coordinates arrive
    ST_P_RD    = 9'b000000100,
    ST_P_START = 9'b000001000,
    ST_P_CALC  = 9'b000010000,
    ST_N_RD    = 9'b000100000,
    ST_N_START = 9'b001000000,
    ST_N_DIV   = 9'b010000000,
    ST_N_OUT   = 9'b100000000
  } state_t;

  // configuration registers
  logic [DECAY_W-1:0]  decay_r;
  logic [PCOUNT_W-1:0] pcount_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decay_r  <= DECAY_RESET;
      pcount_r <= PCOUNT_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_DECAY:  decay_r  <= cfg_ch.data[DECAY_W-1:0];
        CFG_PCOUNT: pcount_r <= cfg_ch.data[PCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp the patch count to 1..MAX_PATCHES; keep the last column index
  logic [IDX_W-1:0] last_col;
  always_comb begin
    if (pcount_r == '0) last_col = '0;
    else if (int'(pcount_r) > MAX_PATCHES) last_col = IDX_W'(MAX_PATCHES - 1);
    else last_col = IDX_W'(pcount_r - PCOUNT_W'(1));
  end

  state_t              state_r, state_nxt;
  logic [IDX_W-1:0]    j_r, j_nxt;
  logic [IDX_W-1:0]    last_r, last_nxt;
  logic [IDX_IN_W-1:0] idx_r, idx_nxt;
  logic [COORD_W-1:0]  self_r, self_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [WEIGHT_W-1:0] w_r, w_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [IDX_IN_W-1:0] out_col_r, out_col_nxt;
  logic [WEIGHT_W-1:0] out_w_r, out_w_nxt;
  logic                out_deg_r, out_deg_nxt;
  logic                out_last_r, out_last_nxt;

  logic in_acc, idx_ok, is_row, diag, degen, out_free, col_last;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign idx_ok   = int'(in_ch.patch_index) < MAX_PATCHES;
  assign is_row   = (in_ch.opcode == OP_ROW);
  assign diag     = (CMP_W'(j_r) == CMP_W'(idx_r));
  assign degen    = (sum_r == '0);
  assign out_free = !out_valid_r || out_ch.ready;
  assign col_last = (j_r == last_r);

  // coordinate store: x low, y high
  logic [COORD_W-1:0] coord_mem [MAX_PATCHES];
  logic [COORD_W-1:0] coord_rd_r;
  logic               cw_en, cr_en;
  logic [IDX_W-1:0]   cr_addr;

  assign cw_en   = in_acc && idx_ok && !is_row;
  assign cr_en   = (in_acc && idx_ok && is_row) || (state_r == ST_P_RD);
  assign cr_addr = (state_r == ST_IDLE) ? IDX_W'(in_ch.patch_index) : j_r;

  always_ff @(posedge clk) begin
    if (cw_en) coord_mem[IDX_W'(in_ch.patch_index)] <= {in_ch.coord_y, in_ch.coord_x};
    if (cr_en) coord_rd_r <= coord_mem[cr_addr];
  end

  // potential buffer of the row being built
  logic [POT_W-1:0] pbuf_mem [MAX_PATCHES];
  logic [POT_W-1:0] pbuf_rd_r;
  logic             pw_en;
  logic [POT_W-1:0] pw_data;

  always_ff @(posedge clk) begin
    if (pw_en) pbuf_mem[j_r] <= pw_data;
    if (state_r == ST_N_RD) pbuf_rd_r <= pbuf_mem[j_r];
  end

  // potential unit
  logic             pot_start, pot_done;
  logic [POT_W-1:0] pot_val;

  assign pot_start = (state_r == ST_P_START) && !diag;

  ddk_potential u_pot (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (pot_start),
    .coord_a   (self_r),
    .coord_b   (coord_rd_r),
    .decay     (decay_r),
    .done      (pot_done),
    .potential (pot_val)
  );

  // normalizer: (p << frac + sum/2) / sum
  logic             nd_start, nd_done;
  logic [NUM_W-1:0] nd_num, nd_q;

  assign nd_start = (state_r == ST_N_START) && !degen && !diag;
  assign nd_num   = NUM_W'({pbuf_rd_r, {WEIGHT_FRAC_BITS{1'b0}}}) + NUM_W'(sum_r >> 1);

  ddk_div #(.N_W(NUM_W), .D_W(SUM_W)) u_ndiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (nd_start),
    .dividend (nd_num),
    .divisor  (sum_r),
    .done     (nd_done),
    .quotient (nd_q)
  );

  always_comb begin
    state_nxt = state_r;
    j_nxt     = j_r;
    last_nxt  = last_r;
    idx_nxt   = idx_r;
    self_nxt  = self_r;
    sum_nxt   = sum_r;
    w_nxt     = w_r;
    pw_en     = 1'b0;
    pw_data   = pot_val;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_col_nxt   = out_col_r;
    out_w_nxt     = out_w_r;
    out_deg_nxt   = out_deg_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && idx_ok && is_row) begin
          idx_nxt   = in_ch.patch_index;
          last_nxt  = last_col;
          j_nxt     = '0;
          sum_nxt   = '0;
          state_nxt = ST_SELF;
        end
      end
      ST_SELF: begin
        self_nxt  = coord_rd_r;
        state_nxt = ST_P_RD;
      end
      ST_P_RD: state_nxt = ST_P_START;
      ST_P_START: begin
        if (diag) begin
          pw_en   = 1'b1;
          pw_data = '0;
          j_nxt   = col_last ? '0 : j_r + IDX_W'(1);
          state_nxt = col_last ? ST_N_RD : ST_P_RD;
        end else begin
          state_nxt = ST_P_CALC;
        end
      end
      ST_P_CALC: begin
        if (pot_done) begin
          pw_en   = 1'b1;
          sum_nxt = sum_r + SUM_W'(pot_val);
          j_nxt   = col_last ? '0 : j_r + IDX_W'(1);
          state_nxt = col_last ? ST_N_RD : ST_P_RD;
        end
      end
      ST_N_RD: state_nxt = ST_N_START;
      ST_N_START: begin
        if (degen || diag) begin
          w_nxt     = '0;
          state_nxt = ST_N_OUT;
        end else begin
          state_nxt = ST_N_DIV;
        end
      end
      ST_N_DIV: begin
        if (nd_done) begin
          w_nxt     = nd_q[WEIGHT_W-1:0];
          state_nxt = ST_N_OUT;
        end
      end
      ST_N_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_col_nxt   = IDX_IN_W'(j_r);
          out_w_nxt     = w_r;
          out_deg_nxt   = degen;
          out_last_nxt  = col_last;
          j_nxt         = j_r + IDX_W'(1);
          state_nxt     = col_last ? ST_IDLE : ST_N_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
    j_r        <= j_nxt;
    last_r     <= last_nxt;
    idx_r      <= idx_nxt;
    self_r     <= self_nxt;
    w_r        <= w_nxt;
    out_col_r  <= out_col_nxt;
    out_w_r    <= out_w_nxt;
    out_deg_r  <= out_deg_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.column_index = out_col_r;
  assign out_ch.weight       = out_w_r;
  assign out_ch.degenerate   = out_deg_r;
  assign out_ch.last         = out_last_r;
endmodule

// ===== rtl/core/ddk_div.sv =====
// ----------------------------------------------------------------------------
// Distance decay kernel row: serial divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ddk_div
  import ddk_pkg::*;
#(
  parameter int N_W = 34,
  parameter int D_W = 22
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [N_W-1:0] dividend,
  input  logic [D_W-1:0] divisor,
  output logic           done,
  output logic [N_W-1:0] quotient
);
  localparam int CNT_W = $clog2(N_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [D_W-1:0]   rem_r, rem_nxt;
  logic [D_W-1:0]   div_r, div_nxt;
  logic [N_W-1:0]   quo_r, quo_nxt;
  logic [D_W:0]     rem_sh;

  assign rem_sh = {rem_r, quo_r[N_W-1]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(N_W);
      rem_nxt  = '0;
      div_nxt  = divisor;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, div_r}) begin
        rem_nxt = D_W'(rem_sh - {1'b0, div_r});
        quo_nxt = {quo_r[N_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[D_W-1:0];
        quo_nxt = {quo_r[N_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;
endmodule

// ===== rtl/core/ddk_potential.sv =====
// ----------------------------------------------------------------------------
// Distance decay kernel row: potential unit
// Distance by digit-serial square root, then exp(-decay * dist) by series
// and repeated multiplies with e^-1, rounded to Q0.16.
// ----------------------------------------------------------------------------
module ddk_potential
  import ddk_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [COORD_W-1:0] coord_a,
  input  logic [COORD_W-1:0] coord_b,
  input  logic [DECAY_W-1:0] decay,
  output logic               done,
  output logic [POT_W-1:0]   potential
);
  localparam int D2_W   = 2 * COORD_BITS + 1;
  localparam int V_W    = D2_W + 8;
  localparam int PV_W   = V_W + (V_W % 2);
  localparam int R_W    = PV_W / 2;
  localparam int RM_W   = R_W + 2;
  localparam int SQC_W  = $clog2(R_W + 1);
  localparam int T_W    = DECAY_W + R_W;
  localparam int TERM_W = 33;
  localparam int ACC_W  = 34;
  localparam int TF_W   = TERM_W + 16;
  localparam int DIV_W  = 34;
  localparam int K_W    = 5;
  localparam int PRD_W  = 2 * TERM_W - 1;

  localparam logic [15:0] E1_LO = EXP_NEG_ONE_Q32[15:0];
  localparam logic [15:0] E1_HI = EXP_NEG_ONE_Q32[31:16];

  typedef enum logic [8:0] {
    P_IDLE  = 9'b000000001,
    P_DIST  = 9'b000000010,
    P_SQRT  = 9'b000000100,
    P_SCALE = 9'b000001000,
    P_EMUL  = 9'b000010000,
    P_EDIV  = 9'b000100000,
    P_POWA  = 9'b001000000,
    P_POWB  = 9'b010000000,
    P_FIN   = 9'b100000000
  } pstate_t;

  pstate_t            state_r, state_nxt;
  logic [COORD_W-1:0] a_r, a_nxt, b_r, b_nxt;
  logic [DECAY_W-1:0] dec_r, dec_nxt;
  logic [PV_W-1:0]    vsh_r, vsh_nxt;
  logic [RM_W-1:0]    rem_r, rem_nxt;
  logic [R_W-1:0]     root_r, root_nxt;
  logic [SQC_W-1:0]   sqc_r, sqc_nxt;
  logic [T_W-1:0]     t_r, t_nxt;
  logic [TERM_W-1:0]  term_r, term_nxt;
  logic [ACC_W-1:0]   pos_r, pos_nxt, neg_r, neg_nxt;
  logic [K_W-1:0]     k_r, k_nxt;
  logic [TERM_W-1:0]  v_r, v_nxt;
  logic [5:0]         n_r, n_nxt;
  logic [TF_W-1:0]    lo_r, lo_nxt;

  logic [COORD_BITS-1:0] xa, ya, xb, yb, dx, dy;
  logic [D2_W-1:0]       d2;
  logic [RM_W+1:0]       rem_sh, trial;
  logic [T_W-16-1:0]     t_int;
  logic [TF_W-1:0]       tf, hi;
  logic [PRD_W-1:0]      full;
  logic [TERM_W-16-1:0]  pround;
  logic                  div_start, div_done;
  logic [DIV_W-1:0]      div_q;

  assign xa = a_r[COORD_BITS-1:0];
  assign ya = a_r[COORD_W-1:COORD_BITS];
  assign xb = b_r[COORD_BITS-1:0];
  assign yb = b_r[COORD_W-1:COORD_BITS];
  assign dx = (xa > xb) ? xa - xb : xb - xa;
  assign dy = (ya > yb) ? ya - yb : yb - ya;
  assign d2 = D2_W'(dx * dx) + D2_W'(dy * dy);

  assign rem_sh = {rem_r, vsh_r[PV_W-1 -: 2]};
  assign trial  = (RM_W + 2)'({root_r, 2'b01});
  assign t_int  = t_r[T_W-1:16];
  assign tf     = {16'b0, term_r} * {{(TF_W-16){1'b0}}, t_r[15:0]};
  assign hi     = {16'b0, v_r} * {{(TF_W-16){1'b0}}, E1_HI};
  assign full   = PRD_W'(lo_r) + (PRD_W'(hi) << 16);
  assign pround = (TERM_W - 16)'((v_r + TERM_W'(32768)) >> 16);

  assign div_start = (state_r == P_EMUL);

  ddk_div #(.N_W(DIV_W), .D_W(K_W)) u_kdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (DIV_W'(tf >> 16)),
    .divisor  (k_r),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_nxt = state_r;
    a_nxt = a_r; b_nxt = b_r; dec_nxt = dec_r;
    vsh_nxt = vsh_r; rem_nxt = rem_r; root_nxt = root_r; sqc_nxt = sqc_r;
    t_nxt = t_r; term_nxt = term_r; pos_nxt = pos_r; neg_nxt = neg_r;
    k_nxt = k_r; v_nxt = v_r; n_nxt = n_r; lo_nxt = lo_r;
    unique case (state_r)
      P_IDLE: begin
        if (start) begin
          a_nxt = coord_a;
          b_nxt = coord_b;
          dec_nxt = decay;
          state_nxt = P_DIST;
        end
      end
      P_DIST: begin
        vsh_nxt  = PV_W'({d2, 8'b0});
        rem_nxt  = '0;
        root_nxt = '0;
        sqc_nxt  = SQC_W'(R_W);
        state_nxt = P_SQRT;
      end
      P_SQRT: begin
        vsh_nxt = vsh_r << 2;
        if (rem_sh >= trial) begin
          rem_nxt  = RM_W'(rem_sh - trial);
          root_nxt = {root_r[R_W-2:0], 1'b1};
        end else begin
          rem_nxt  = rem_sh[RM_W-1:0];
          root_nxt = {root_r[R_W-2:0], 1'b0};
        end
        sqc_nxt = sqc_r - SQC_W'(1);
        if (sqc_r == SQC_W'(1)) state_nxt = P_SCALE;
      end
      P_SCALE: begin
        // t = decay * dist, Q.16
        t_nxt    = T_W'(dec_r) * T_W'(root_r);
        term_nxt = TERM_W'(64'h1_0000_0000);
        pos_nxt  = ACC_W'(64'h1_0000_0000);
        neg_nxt  = '0;
        k_nxt    = K_W'(1);
        state_nxt = P_EMUL;
      end
      P_EMUL: begin
        // beyond e^-40 the potential is zero
        if (int'(t_int) > EXP_N_MAX) begin
          v_nxt = '0;
          state_nxt = P_FIN;
        end else begin
          state_nxt = P_EDIV;
        end
      end
      P_EDIV: begin
        if (div_done) begin
          term_nxt = div_q[TERM_W-1:0];
          if (k_r[0]) neg_nxt = neg_r + ACC_W'(div_q[TERM_W-1:0]);
          else pos_nxt = pos_r + ACC_W'(div_q[TERM_W-1:0]);
          if (k_r == K_W'(TAYLOR_TERMS)) begin
            state_nxt = P_POWA;
            n_nxt = 6'(t_int);
            if (k_r[0]) begin
              v_nxt = (pos_r > neg_nxt) ? TERM_W'(pos_r - neg_nxt) : '0;
            end else begin
              v_nxt = (pos_nxt > neg_r) ? TERM_W'(pos_nxt - neg_r) : '0;
            end
          end else begin
            k_nxt = k_r + K_W'(1);
            state_nxt = P_EMUL;
          end
        end
      end
      P_POWA: begin
        if (n_r == '0) begin
          state_nxt = P_FIN;
        end else begin
          lo_nxt = {16'b0, v_r} * {{(TF_W-16){1'b0}}, E1_LO};
          state_nxt = P_POWB;
        end
      end
      P_POWB: begin
        // v * e^-1, rounded half up
        v_nxt = TERM_W'((full + PRD_W'(64'h8000_0000)) >> 32);
        n_nxt = n_r - 6'd1;
        state_nxt = P_POWA;
      end
      P_FIN: state_nxt = P_IDLE;
      default: state_nxt = P_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= P_IDLE;
    else state_r <= state_nxt;
    a_r <= a_nxt; b_r <= b_nxt; dec_r <= dec_nxt;
    vsh_r <= vsh_nxt; rem_r <= rem_nxt; root_r <= root_nxt; sqc_r <= sqc_nxt;
    t_r <= t_nxt; term_r <= term_nxt; pos_r <= pos_nxt; neg_r <= neg_nxt;
    k_r <= k_nxt; v_r <= v_nxt; n_r <= n_nxt; lo_r <= lo_nxt;
  end

  assign done      = (state_r == P_FIN);
  assign potential = (pround > (TERM_W - 16)'(65535)) ? POT_W'(65535) : POT_W'(pround);
endmodule

// ===== rtl/core/ddk_checker.sv =====
// ----------------------------------------------------------------------------
// Distance decay kernel row: port checker
// Assertions on the top level ports, bound to the top level.
// ----------------------------------------------------------------------------
module ddk_checker
  import ddk_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [IDX_IN_W-1:0] out_column_index,
  input logic [WEIGHT_W-1:0] out_weight,
  input logic                out_degenerate,
  input logic                out_last
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_column_index)
      && $stable(out_weight) && $stable(out_last))
    else $error("result item changed while stalled");

  a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_weight <= WEIGHT_W'(1 << WEIGHT_FRAC_BITS))
    else $error("weight above one");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_weight == '0)
    else $error("degenerate row with nonzero weight");

  a_row_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input taken in the middle of a row");

  a_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> !out_valid)
    else $error("result after the last column");
endmodule

bind distance_decay_kernel_row_top ddk_checker u_ddk_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_column_index (out_ch.column_index),
  .out_weight       (out_ch.weight),
  .out_degenerate   (out_ch.degenerate),
  .out_last         (out_ch.last)
);

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// Distance decay kernel row: testbench
// Loads patch coordinates, requests kernel rows under several register
// settings and checks every normalized weight against a local predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

import ddk_pkg::*;

typedef struct packed {
  logic [IDX_IN_W-1:0] column_index;
  logic [WEIGHT_W-1:0] weight;
  logic                degenerate;
  logic                last;
} kernel_weight_t;

class kernel_row_scoreboard;
  logic [COORD_W-1:0]  coords[MAX_PATCHES_DEF];
  logic [DECAY_W-1:0]  decay;
  logic [PCOUNT_W-1:0] pcount;
  kernel_weight_t      pending_weights[$];
  int                  mismatches;

  function new();
    decay      = DECAY_RESET;
    pcount     = PCOUNT_RESET;
    mismatches = 0;
  endfunction

  function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    if (idx == CFG_DECAY) decay = data;
    else if (idx == CFG_PCOUNT) pcount = data[PCOUNT_W-1:0];
  endfunction

  // e^-f in Q0.32, alternating series with even/odd sums kept apart
  function longint unsigned exp_series(longint unsigned f);
    longint unsigned term = 64'h1_0000_0000;
    longint unsigned pos  = 64'h1_0000_0000;
    longint unsigned neg  = 0;
    for (int k = 1; k <= TAYLOR_TERMS; k++) begin
      term = (term * f) / (longint'(k) << 16);
      if (k % 2) neg += term;
      else pos += term;
    end
    return (pos > neg) ? pos - neg : 0;
  endfunction

  function longint unsigned exp_neg(longint unsigned t);
    longint unsigned n = t >> 16;
    longint unsigned v;
    longint unsigned e1;
    if (n > EXP_N_MAX) return 0;
    v  = exp_series(t & 16'hFFFF);
    e1 = exp_series(65536);
    for (longint unsigned k = 0; k < n; k++)
      v = (v * e1 + (64'd1 << 31)) >> 32;
    return v;
  endfunction

  function longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res = 0;
    longint unsigned b   = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v  -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function longint unsigned potential(logic [COORD_W-1:0] a, logic [COORD_W-1:0] b);
    longint unsigned xa = a[COORD_BITS-1:0];
    longint unsigned ya = a[COORD_W-1:COORD_BITS];
    longint unsigned xb = b[COORD_BITS-1:0];
    longint unsigned yb = b[COORD_W-1:COORD_BITS];
    longint unsigned dx = (xa > xb) ? xa - xb : xb - xa;
    longint unsigned dy = (ya > yb) ? ya - yb : yb - ya;
    longint unsigned span = int_sqrt((dx * dx + dy * dy) << 8);
    longint unsigned p = (exp_neg(longint'(decay) * span) + 32768) >> 16;
    return (p > 65535) ? 65535 : p;
  endfunction

  function void note_input(opcode_t op, logic [IDX_IN_W-1:0] idx,
                           logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y);
    int              count;
    longint unsigned pots[MAX_PATCHES_DEF];
    longint unsigned row_sum = 0;
    kernel_weight_t  w;
    if (op == OP_LOAD) begin
      coords[idx] = {y, x};
      return;
    end
    count = (pcount == 0) ? 1 : (pcount > MAX_PATCHES_DEF) ? MAX_PATCHES_DEF : pcount;
    for (int j = 0; j < count; j++) begin
      pots[j] = (j == idx) ? 0 : potential(coords[idx], coords[j]);
      row_sum += pots[j];
    end
    for (int j = 0; j < count; j++) begin
      w.column_index = IDX_IN_W'(j);
      w.degenerate   = (row_sum == 0);
      w.last         = (j == count - 1);
      w.weight       = (row_sum == 0 || j == idx) ? '0 :
                       WEIGHT_W'(((pots[j] << WEIGHT_FRAC_BITS) + row_sum / 2) / row_sum);
      pending_weights = {pending_weights, w};
    end
  endfunction

  function void check_result(kernel_weight_t got);
    kernel_weight_t exp_w;
    if (pending_weights.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected weight: col %0d w %0d", got.column_index, got.weight);
      return;
    end
    exp_w = pending_weights.pop_front();
    if (got != exp_w) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"weight mismatch: exp col %0d w %0d deg %0b last %0b,",
                  " got col %0d w %0d deg %0b last %0b"},
                 exp_w.column_index, exp_w.weight, exp_w.degenerate, exp_w.last,
                 got.column_index, got.weight, got.degenerate, got.last);
    end
  endfunction
endclass

module tb_top;
  localparam int CYCLE_LIMIT = 5_000_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #6 clk = ~clk;

  ddk_in_if  in_if();
  ddk_out_if out_if();
  ddk_cfg_if cfg_if();

  distance_decay_kernel_row_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  kernel_row_scoreboard sb = new();

  bit tx_calm = 1'b0;    // sender never idles while set
  bit rx_calm = 1'b0;    // receiver never stalls while set
  int rx_hold = 0;       // cycles of forced receiver hold-off
  int cycles  = 0;
  int cx, cy;            // cluster center for coordinate loads

  initial begin
    in_if.valid = 1'b0;
    in_if.opcode = OP_LOAD;
    in_if.patch_index = '0;
    in_if.coord_x = '0;
    in_if.coord_y = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_DECAY;
    cfg_if.data = '0;
    out_if.ready = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // receiver: random stalls, optional long hold-off
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      out_if.ready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else if (rx_calm) begin
      out_if.ready <= 1'b1;
    end else begin
      out_if.ready <= ($urandom_range(99) >= 12);
    end
  end

  always @(posedge clk) begin
    kernel_weight_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.column_index = out_if.column_index;
      got.weight       = out_if.weight;
      got.degenerate   = out_if.degenerate;
      got.last         = out_if.last;
      sb.check_result(got);
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high, so back-to-back items need no re-raise.
  task automatic send_item(opcode_t op, int idx, int x, int y);
    while (!tx_calm && $urandom_range(99) < 12) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid       = 1'b1;
    in_if.opcode      = op;
    in_if.patch_index = IDX_IN_W'(idx);
    in_if.coord_x     = COORD_BITS'(x);
    in_if.coord_y     = COORD_BITS'(y);
    do @(posedge clk); while (!in_if.ready);
    sb.note_input(op, IDX_IN_W'(idx), COORD_BITS'(x), COORD_BITS'(y));
    @(negedge clk);
  endtask

  // all results in, then let a trailing load settle
  task automatic drain();
    in_if.valid = 1'b0;
    while (sb.pending_weights.size() != 0) @(negedge clk);
    repeat (64) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, int data);
    drain();
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = CFG_DATA_W'(data);
    do @(posedge clk); while (!cfg_if.ready);
    sb.write_reg(idx, CFG_DATA_W'(data));
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // mostly clustered so potentials stay nonzero; some loads land anywhere
  task automatic load_random(int idx);
    if ($urandom_range(9) == 0)
      send_item(OP_LOAD, idx, $urandom_range(1023), $urandom_range(1023));
    else
      send_item(OP_LOAD, idx, (cx + $urandom_range(12)) % 1024,
                (cy + $urandom_range(12)) % 1024);
  endtask

  task automatic random_phase(int decay, int count, int n_items);
    write_reg(CFG_DECAY, decay);
    write_reg(CFG_PCOUNT, count);
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(99) < 65) send_item(OP_ROW, $urandom_range(63), 0, 0);
      else load_random($urandom_range(63));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: far corners, unit step, coincident pair, unused row patch
    write_reg(CFG_PCOUNT, 2);
    send_item(OP_LOAD, 0, 0, 0);
    send_item(OP_LOAD, 1, 1023, 1023);
    send_item(OP_LOAD, 2, 1, 0);
    send_item(OP_LOAD, 3, 0, 0);
    send_item(OP_LOAD, 63, 1023, 0);
    send_item(OP_ROW, 0, 0, 0);        // far apart: degenerate row
    send_item(OP_ROW, 1, 0, 0);
    write_reg(CFG_PCOUNT, 4);
    send_item(OP_ROW, 0, 0, 0);        // coincident and unit-distance columns
    send_item(OP_ROW, 2, 0, 0);
    send_item(OP_ROW, 63, 1023, 1023); // row patch outside the count
    write_reg(CFG_PCOUNT, 0);          // taken as one column: diagonal only
    send_item(OP_ROW, 0, 0, 0);
    write_reg(CFG_PCOUNT, 4);
    write_reg(CFG_DECAY, 0);
    send_item(OP_ROW, 3, 0, 0);        // no decay: equal weights
    write_reg(CFG_DECAY, 65535);
    send_item(OP_ROW, 0, 0, 0);        // only the coincident column survives
    send_item(OP_ROW, 1, 0, 0);

    // fill the whole store, no idling on either side
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    cx = $urandom_range(1023);
    cy = $urandom_range(1023);
    for (int i = 0; i < MAX_PATCHES_DEF; i++) load_random(i);
    tx_calm = 1'b0;
    rx_calm = 1'b0;

    // full-width rows, including a count above the store size
    write_reg(CFG_DECAY, 0);
    write_reg(CFG_PCOUNT, 127);
    send_item(OP_ROW, $urandom_range(63), 0, 0);
    write_reg(CFG_DECAY, 300);
    write_reg(CFG_PCOUNT, 64);
    send_item(OP_ROW, $urandom_range(63), 0, 0);
    write_reg(CFG_DECAY, 65535);
    send_item(OP_ROW, $urandom_range(63), 0, 0);

    // receiver holds off long while six-column rows keep coming
    drain();
    rx_hold = 20000;
    random_phase(1024, 6, 12);

    for (int p = 0; p < 8; p++) begin
      cx = $urandom_range(1023);
      cy = $urandom_range(1023);
      if (p == 3) begin
        tx_calm = 1'b1;
        rx_calm = 1'b1;
      end
      random_phase(($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(3000),
                   $urandom_range(2, 6), 11);
      drain();                         // sender waits for every result
      random_phase($urandom_range(4096), $urandom_range(1, 5), 11);
      tx_calm = 1'b0;
      rx_calm = 1'b0;
    end

    drain();
    repeat (200) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending_weights.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/core/ddk_pkg.sv
rtl/core/ddk_ifs.sv
rtl/core/ddk_div.sv
rtl/core/ddk_potential.sv
rtl/core/distance_decay_kernel_row_top.sv
rtl/core/ddk_checker.sv
bench/tb_top.sv
